/* hdl/dqs_pkg.sv */
package dqs_pkg;

	localparam int unsigned CAPACITY_DEF = 16;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned REC_W        = 2 * DATA_W;
	localparam int unsigned OCC_W        = 5;
	localparam int unsigned REQ_W        = 3;
	localparam int unsigned CMDQ_DEPTH   = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd5;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_REAR,
		OP_POP_FRONT,
		OP_POP_REAR,
		OP_SEARCH,
		OP_REVERSE,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN
	} state_t;

	typedef struct packed {
		op_t                       op;
		logic signed [DATA_W-1:0]  key;
		logic        [DATA_W-1:0]  tag;
	} cmd_t;

	function automatic op_t decode_req(input logic [REQ_W-1:0] req);
		op_t op;
		unique case (req)
			REQ_PUSH_FRONT: op = OP_PUSH_FRONT;
			REQ_PUSH_REAR:  op = OP_PUSH_REAR;
			REQ_POP_FRONT:  op = OP_POP_FRONT;
			REQ_POP_REAR:   op = OP_POP_REAR;
			REQ_SEARCH:     op = OP_SEARCH;
			REQ_REVERSE:    op = OP_REVERSE;
			default:        op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

/* hdl/dqs_ram.sv */
module dqs_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/dqs_front.sv */
module dqs_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [dqs_pkg::REQ_W-1:0]           req_type,
	input  logic signed [dqs_pkg::DATA_W-1:0]   key_id,
	input  logic [dqs_pkg::DATA_W-1:0]          tag_in,
	output logic                                cmd_valid,
	output dqs_pkg::cmd_t                       cmd,
	input  logic                                cmd_pop
);

	localparam int unsigned D  = dqs_pkg::CMDQ_DEPTH;
	localparam int unsigned PW = $clog2(D);
	localparam int unsigned NW = $clog2(D + 1);

	dqs_pkg::cmd_t  cmdq_q [D];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [NW-1:0]  cnt_q;
	logic           push;
	logic           pop;
	dqs_pkg::cmd_t  new_cmd;

	assign req_stall = (cnt_q == NW'(D));
	assign push      = req_valid && !req_stall;
	assign pop       = cmd_pop && cmd_valid;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cmdq_q[rptr_q];

	always_comb begin
		new_cmd.op  = dqs_pkg::decode_req(req_type);
		new_cmd.key = key_id;
		new_cmd.tag = tag_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmdq_q[wptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(D - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(D - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/dqs_back.sv */
module dqs_back #(
	parameter int unsigned CAPACITY = dqs_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	input  dqs_pkg::cmd_t                       cmd,
	output logic                                cmd_pop,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [1:0]                          status,
	output logic signed [dqs_pkg::DATA_W-1:0]   out_id,
	output logic [dqs_pkg::DATA_W-1:0]          tag_out,
	output logic [dqs_pkg::OCC_W-1:0]           occupancy
);

	localparam int unsigned SW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned DW = dqs_pkg::DATA_W;
	localparam int unsigned RW = dqs_pkg::REC_W;

	function automatic logic [SW-1:0] step(input logic [SW-1:0] s, input logic back);
		logic [SW-1:0] r;
		if (back) begin
			r = (s == '0) ? SW'(CAPACITY - 1) : s - 1'b1;
		end else begin
			r = (s == SW'(CAPACITY - 1)) ? '0 : s + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [SW-1:0] slot_at(input logic [SW-1:0] h, input logic rev,
			input logic [CW-1:0] pos);
		logic [SW:0] hx;
		logic [SW:0] px;
		logic [SW:0] sum;
		hx = {1'b0, h};
		px = (SW+1)'(pos);
		if (rev) begin
			sum = (hx >= px) ? hx - px : hx + (SW+1)'(CAPACITY) - px;
		end else begin
			sum = hx + px;
			if (sum >= (SW+1)'(CAPACITY)) begin
				sum = sum - (SW+1)'(CAPACITY);
			end
		end
		return sum[SW-1:0];
	endfunction

	dqs_pkg::state_t  state_q, state_d;
	logic [SW-1:0]    head_q, head_d;
	logic [CW-1:0]    count_q, count_d;
	logic             rev_q, rev_d;
	logic signed [DW-1:0] key_q;
	logic [SW-1:0]    scan_q;
	logic [CW-1:0]    pos_q;
	logic             cmp_vld_q;
	logic             cmp_last_q;

	logic             rsp_vld_q;
	dqs_pkg::status_t status_q;
	logic signed [DW-1:0] id_q;
	logic [DW-1:0]    tag_q;
	logic [CW-1:0]    occ_q;

	logic             free;
	logic             start;
	logic             full;
	logic             empty;
	logic             issue;
	logic             hit;
	logic             wr_en;
	logic [SW-1:0]    wr_addr;
	logic [RW-1:0]    wr_data;
	logic             rd_en;
	logic [SW-1:0]    rd_addr;
	logic [RW-1:0]    rd_data;
	logic             res_ld;
	logic             res_data;
	dqs_pkg::status_t res_status;
	logic [SW-1:0]    new_head;

	assign free  = !rsp_vld_q || !rsp_stall;
	assign start = (state_q == dqs_pkg::ST_IDLE) && cmd_valid && free;
	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign issue = (pos_q != count_q);
	assign hit   = cmp_vld_q && (rd_data[RW-1:DW] == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dqs_pkg::ST_IDLE: begin
				if (start && !empty) begin
					if (cmd.op == dqs_pkg::OP_POP_FRONT || cmd.op == dqs_pkg::OP_POP_REAR) begin
						state_d = dqs_pkg::ST_READ;
					end else if (cmd.op == dqs_pkg::OP_SEARCH) begin
						state_d = dqs_pkg::ST_SCAN;
					end
				end
			end
			dqs_pkg::ST_READ: state_d = dqs_pkg::ST_IDLE;
			dqs_pkg::ST_SCAN: begin
				if (hit || (cmp_vld_q && cmp_last_q)) begin
					state_d = dqs_pkg::ST_IDLE;
				end
			end
			default: state_d = dqs_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		cmd_pop    = start;
		wr_en      = 1'b0;
		wr_addr    = head_q;
		wr_data    = {cmd.key, cmd.tag};
		rd_en      = 1'b0;
		rd_addr    = head_q;
		res_ld     = 1'b0;
		res_data   = 1'b0;
		res_status = dqs_pkg::STAT_OK;
		head_d     = head_q;
		count_d    = count_q;
		rev_d      = rev_q;
		new_head   = (count_q != '0) ? step(head_q, !rev_q) : head_q;
		unique case (state_q)
			dqs_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd.op)
						dqs_pkg::OP_PUSH_FRONT, dqs_pkg::OP_PUSH_REAR: begin
							res_ld = 1'b1;
							if (full) begin
								res_status = dqs_pkg::STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + 1'b1;
								if (cmd.op == dqs_pkg::OP_PUSH_FRONT) begin
									head_d  = new_head;
									wr_addr = new_head;
								end else begin
									wr_addr = slot_at(head_q, rev_q, count_q);
								end
							end
						end
						dqs_pkg::OP_POP_FRONT, dqs_pkg::OP_POP_REAR: begin
							if (empty) begin
								res_ld     = 1'b1;
								res_status = dqs_pkg::STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								count_d = count_q - 1'b1;
								if (cmd.op == dqs_pkg::OP_POP_FRONT) begin
									rd_addr = head_q;
									if (count_q > CW'(1)) begin
										head_d = step(head_q, rev_q);
									end
								end else begin
									rd_addr = slot_at(head_q, rev_q, count_q - 1'b1);
								end
							end
						end
						dqs_pkg::OP_SEARCH: begin
							if (empty) begin
								res_ld     = 1'b1;
								res_status = dqs_pkg::STAT_EMPTY;
							end
						end
						dqs_pkg::OP_REVERSE: begin
							res_ld = 1'b1;
							if (count_q >= CW'(2)) begin
								head_d = slot_at(head_q, rev_q, count_q - 1'b1);
								rev_d  = !rev_q;
							end
						end
						default: begin
							res_ld = 1'b1;
						end
					endcase
				end
			end
			dqs_pkg::ST_READ: begin
				res_ld   = 1'b1;
				res_data = 1'b1;
			end
			dqs_pkg::ST_SCAN: begin
				rd_en   = issue;
				rd_addr = scan_q;
				if (hit) begin
					res_ld   = 1'b1;
					res_data = 1'b1;
				end else if (cmp_vld_q && cmp_last_q) begin
					res_ld     = 1'b1;
					res_status = dqs_pkg::STAT_NOT_FOUND;
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	dqs_ram #(
		.WIDTH (RW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dqs_pkg::ST_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			rev_q      <= 1'b0;
			cmp_vld_q  <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			rev_q   <= rev_d;
			if (state_q == dqs_pkg::ST_SCAN) begin
				cmp_vld_q <= issue;
			end else begin
				cmp_vld_q <= 1'b0;
			end
			if (res_ld) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// search walk and result payload
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= cmd.key;
			scan_q <= head_q;
			pos_q  <= '0;
		end else if (state_q == dqs_pkg::ST_SCAN && issue) begin
			scan_q <= step(scan_q, rev_q);
			pos_q  <= pos_q + 1'b1;
		end
		cmp_last_q <= ((pos_q + 1'b1) == count_q);
		if (res_ld) begin
			status_q <= res_status;
			occ_q    <= count_d;
			if (res_data) begin
				id_q  <= rd_data[RW-1:DW];
				tag_q <= rd_data[DW-1:0];
			end else begin
				id_q  <= '0;
				tag_q <= '0;
			end
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign status    = status_q;
	assign out_id    = id_q;
	assign tag_out   = tag_q;
	assign occupancy = dqs_pkg::OCC_W'(occ_q);

endmodule

/* hdl/double_ended_queue_with_search.sv */
// Double-ended queue of up to CAPACITY {id, tag} records in a ring buffer with a
// direction flag. Each request (push front/rear, pop front/rear, search by id,
// reverse) gives exactly one response with status, record and occupancy after the
// request. Requests enter a two-entry command queue and run one at a time on a
// record memory with one write and one registered read port. Push, reverse, unused
// codes and empty pops answer when accepted, other pops after the read; a search
// reads one record per cycle from the front up to a hit or the end; the read port
// sets the rate. The record memory is not cleared at reset and needs no startup pass.
module double_ended_queue_with_search #(
	parameter int unsigned CAPACITY = dqs_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [dqs_pkg::REQ_W-1:0]           req_type,
	input  logic signed [dqs_pkg::DATA_W-1:0]   key_id,
	input  logic [dqs_pkg::DATA_W-1:0]          tag_in,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [1:0]                          status,
	output logic signed [dqs_pkg::DATA_W-1:0]   out_id,
	output logic [dqs_pkg::DATA_W-1:0]          tag_out,
	output logic [dqs_pkg::OCC_W-1:0]           occupancy
);

	logic          cmd_valid;
	logic          cmd_pop;
	dqs_pkg::cmd_t cmd;

	dqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.key_id    (key_id),
		.tag_in    (tag_in),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	dqs_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.out_id    (out_id),
		.tag_out   (tag_out),
		.occupancy (occupancy)
	);

endmodule
